FILE: rtl/core/masked_byte_signature_matcher_unit_assert.svh
// assertion macros used by the checker file
`ifndef MASKED_BYTE_SIGNATURE_MATCHER_UNIT_ASSERT_SVH
`define MASKED_BYTE_SIGNATURE_MATCHER_UNIT_ASSERT_SVH

// same-cycle implication, muted during reset
`define MBSM_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("mbsm check failed");

// next-cycle implication, muted during reset
`define MBSM_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("mbsm check failed");

`endif

FILE: rtl/core/mbsm_pkg.sv
package mbsm_pkg;

  localparam int MAX_PATTERN_BYTES = 8;
  localparam int OFFSET_BITS = 32;

  localparam int BYTE_W = 8;
  localparam int LEN_W = 4;
  localparam int CARE_BITS = 8;
  localparam int CARE_IDX_W = $clog2(CARE_BITS);
  localparam int PATTERN_W = 64;
  localparam int COUNT_W = 32;
  localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
  localparam int SUPP_W = IDX_W;
  localparam int CMP_W = IDX_W + LEN_W;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = PATTERN_W;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CARE_MASK = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_IGNORE_CASE = 2'd3;

  localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

  typedef struct packed {
    logic [PATTERN_W-1:0] pattern_bytes;
    logic [CARE_BITS-1:0] care_mask;
    logic [LEN_W-1:0]     pattern_length;
    logic                 ignore_case;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } in_word_t;

  typedef struct packed {
    logic               match_found;
    logic [31:0]        match_offset;
    logic               buffer_done;
    logic [COUNT_W-1:0] match_total;
  } out_word_t;

  function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] r;
    r = b;
    if (b inside {[8'h41:8'h5A]}) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/masked_byte_signature_matcher_unit.sv
// a result is registered and shows on dst in the cycle after its byte is accepted
// throughput: one byte per cycle while src is not stalled; every window position is compared at once by the cell row
// src is stalled only while a result waits in the output register and dst stalls
// rst (synchronous, active high) clears window, offset, suppression, match count,
// output valid and sets the registers to pattern 0, care 0xFF, length 0, case fold off
module masked_byte_signature_matcher_unit import mbsm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   src_valid,
  output logic                   src_stall,
  input  in_word_t               src_word,
  output logic                   dst_valid,
  input  logic                   dst_stall,
  output out_word_t              dst_word,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t                   cfg;
  logic [OFFSET_BITS-1:0] byte_position;
  logic [SUPP_W-1:0]      suppress_count;
  logic [COUNT_W-1:0]     match_counter;

  logic                   take;
  logic [BYTE_W-1:0]      chain [MAX_PATTERN_BYTES+1];
  logic [MAX_PATTERN_BYTES-1:0] cell_ok;

  logic [LEN_W-1:0]       len_m1;
  logic [OFFSET_BITS-1:0] len_m1_ext;
  logic                   len_ok;
  logic                   hit;
  logic [OFFSET_BITS-1:0] start;
  logic [OFFSET_BITS+31:0] start_wide;
  logic [COUNT_W-1:0]     count_next;
  out_word_t              result_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_bytes  <= '0;
      cfg.care_mask      <= {CARE_BITS{1'b1}};
      cfg.pattern_length <= '0;
      cfg.ignore_case    <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PATTERN_BYTES:  cfg.pattern_bytes  <= cfg_data[PATTERN_W-1:0];
        REG_CARE_MASK:      cfg.care_mask      <= cfg_data[CARE_BITS-1:0];
        REG_PATTERN_LENGTH: cfg.pattern_length <= cfg_data[LEN_W-1:0];
        REG_IGNORE_CASE:    cfg.ignore_case    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign src_stall = dst_valid && dst_stall;
  assign take      = src_valid && !src_stall;

  // window shifts one cell per accepted word, newest byte into cell 0
  assign chain[0] = src_word.data_byte;

  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
    mbsm_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .advance    (take),
      .clear      (src_word.last_byte),
      .byte_in    (chain[k]),
      .cell_index (IDX_W'(k)),
      .cfg        (cfg),
      .byte_out   (chain[k+1]),
      .cmp_ok     (cell_ok[k])
    );
  end

  always_comb begin
    len_m1     = cfg.pattern_length - LEN_W'(1);
    len_m1_ext = {{(OFFSET_BITS-LEN_W){1'b0}}, len_m1};
    len_ok     = (cfg.pattern_length != '0) &&
                 ({{IDX_W{1'b0}}, cfg.pattern_length} <= CMP_W'(MAX_PATTERN_BYTES));
    hit        = (suppress_count == '0) && len_ok && (byte_position >= len_m1_ext) &&
                 (&cell_ok);
    start      = hit ? (byte_position - len_m1_ext) : '0;
    start_wide = {32'b0, start};
    count_next = (hit && (match_counter != COUNT_MAX)) ? match_counter + COUNT_W'(1)
                                                       : match_counter;
    result_next.match_found  = hit;
    result_next.match_offset = start_wide[31:0];
    result_next.buffer_done  = src_word.last_byte;
    result_next.match_total  = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      suppress_count <= '0;
      match_counter  <= '0;
    end else if (take) begin
      if (src_word.last_byte) begin
        byte_position  <= '0;
        suppress_count <= '0;
        match_counter  <= '0;
      end else begin
        if (byte_position != POS_MAX) begin
          byte_position <= byte_position + OFFSET_BITS'(1);
        end
        if (suppress_count != '0) begin
          suppress_count <= suppress_count - SUPP_W'(1);
        end else if (hit) begin
          suppress_count <= len_m1[SUPP_W-1:0];
        end
        match_counter <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (take) begin
      dst_valid <= hit || src_word.last_byte;
    end else if (!dst_stall) begin
      dst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      dst_word <= result_next;
    end
  end

endmodule

FILE: rtl/core/mbsm_cell.sv
module mbsm_cell import mbsm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              clear,
  input  logic [BYTE_W-1:0] byte_in,
  input  logic [IDX_W-1:0]  cell_index,
  input  cfg_t              cfg,
  output logic [BYTE_W-1:0] byte_out,
  output logic              cmp_ok
);

  logic [BYTE_W-1:0] window_byte;
  logic [CMP_W-1:0]  idx_ext;
  logic [CMP_W-1:0]  len_ext;
  logic [CMP_W-1:0]  pat_pos;
  logic              active;
  logic              cared;
  logic [BYTE_W-1:0] pat_byte;
  logic [BYTE_W-1:0] d_cmp;
  logic [BYTE_W-1:0] p_cmp;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_byte <= '0;
    end else if (advance) begin
      window_byte <= clear ? '0 : byte_in;
    end
  end

  assign byte_out = window_byte;

  // this cell sees window entry cell_index, which lines up with
  // signature byte pattern_length-1-cell_index
  always_comb begin
    idx_ext  = {{LEN_W{1'b0}}, cell_index};
    len_ext  = {{IDX_W{1'b0}}, cfg.pattern_length};
    active   = idx_ext < len_ext;
    pat_pos  = len_ext - idx_ext - CMP_W'(1);
    cared    = (pat_pos < CMP_W'(CARE_BITS)) && cfg.care_mask[pat_pos[CARE_IDX_W-1:0]];
    pat_byte = cfg.pattern_bytes[{pat_pos[CARE_IDX_W-1:0], 3'b000} +: BYTE_W];
    d_cmp    = cfg.ignore_case ? fold_case(byte_in) : byte_in;
    p_cmp    = cfg.ignore_case ? fold_case(pat_byte) : pat_byte;
    cmp_ok   = !active || !cared || (d_cmp == p_cmp);
  end

endmodule

FILE: rtl/core/mbsm_checker.sv
`include "masked_byte_signature_matcher_unit_assert.svh"

module mbsm_checker import mbsm_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      src_valid,
  input logic      src_stall,
  input in_word_t  src_word,
  input logic      dst_valid,
  input logic      dst_stall,
  input out_word_t dst_word
);

  `MBSM_ASSERT_NEXT(a_dst_hold, clk, rst, dst_valid && dst_stall, dst_valid && $stable(dst_word))

  `MBSM_ASSERT_NOW(a_result_reason, clk, rst, dst_valid, dst_word.match_found || dst_word.buffer_done)

  `MBSM_ASSERT_NOW(a_offset_zero, clk, rst, dst_valid && !dst_word.match_found, dst_word.match_offset == '0)

  `MBSM_ASSERT_NEXT(a_last_closes, clk, rst, src_valid && !src_stall && src_word.last_byte, dst_valid && dst_word.buffer_done)

  `MBSM_ASSERT_NOW(a_full_stalls_src, clk, rst, dst_valid && dst_stall, src_stall)

endmodule

bind masked_byte_signature_matcher_unit mbsm_checker u_mbsm_checker (
  .clk       (clk),
  .rst       (rst),
  .src_valid (src_valid),
  .src_stall (src_stall),
  .src_word  (src_word),
  .dst_valid (dst_valid),
  .dst_stall (dst_stall),
  .dst_word  (dst_word)
);

FILE: bench/signature_match_checker.sv
module signature_match_checker import mbsm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   src_valid,
  input  logic                   src_stall,
  input  in_word_t               src_word,
  input  logic                   dst_valid,
  input  logic                   dst_stall,
  input  out_word_t              dst_word,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  // signature settings as seen by the block
  logic [PATTERN_W-1:0]   sig_bytes;
  logic [CARE_BITS-1:0]   sig_care;
  logic [LEN_W-1:0]       sig_len;
  logic                   fold_on;

  // scan state, recent[0] is the newest byte
  logic [BYTE_W-1:0]      recent [MAX_PATTERN_BYTES];
  logic [OFFSET_BITS-1:0] offset_now;
  logic [SUPP_W-1:0]      skip_left;
  logic [COUNT_W-1:0]     hits_in_buffer;

  out_word_t awaited_reports [$];

  function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] b);
    if (b >= 8'h41 && b <= 8'h5A) begin
      return b + 8'h20;
    end
    return b;
  endfunction

  // oldest byte of the window lines up with signature byte 0
  function automatic bit window_hit(input int len);
    logic [BYTE_W-1:0] d;
    logic [BYTE_W-1:0] p;
    for (int j = 0; j < len; j++) begin
      if (j < CARE_BITS && sig_care[j]) begin
        d = recent[len - 1 - j];
        p = sig_bytes[8*j +: 8];
        if (fold_on) begin
          d = to_lower(d);
          p = to_lower(p);
        end
        if (d != p) begin
          return 1'b0;
        end
      end
    end
    return 1'b1;
  endfunction

  task automatic clear_scan();
    foreach (recent[k]) begin
      recent[k] = '0;
    end
    offset_now = '0;
    skip_left = '0;
    hits_in_buffer = '0;
  endtask

  task automatic scan_byte(input in_word_t w);
    int len;
    bit hit;
    logic [OFFSET_BITS-1:0] start;
    out_word_t r;
    for (int k = MAX_PATTERN_BYTES - 1; k > 0; k--) begin
      recent[k] = recent[k-1];
    end
    recent[0] = w.data_byte;
    len = sig_len;
    hit = 1'b0;
    start = '0;
    if (skip_left != 0) begin
      skip_left = skip_left - 1'b1;
    end else if (len >= 1 && len <= MAX_PATTERN_BYTES &&
                 offset_now >= OFFSET_BITS'(len - 1)) begin
      if (window_hit(len)) begin
        hit = 1'b1;
        start = offset_now - OFFSET_BITS'(len - 1);
        skip_left = SUPP_W'(len - 1);
        if (hits_in_buffer != COUNT_MAX) begin
          hits_in_buffer = hits_in_buffer + 1'b1;
        end
      end
    end
    if (offset_now != POS_MAX) begin
      offset_now = offset_now + 1'b1;
    end
    if (hit || w.last_byte) begin
      r.match_found = hit;
      r.match_offset = start[31:0];
      r.buffer_done = w.last_byte;
      r.match_total = hits_in_buffer;
      awaited_reports.insert(awaited_reports.size(), r);
    end
    if (w.last_byte) begin
      clear_scan();
    end
  endtask

  task automatic compare_word(input out_word_t got);
    out_word_t want;
    if (awaited_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("%0t: unexpected word found=%0b offset=%0d done=%0b total=%0d", $realtime,
                 got.match_found, got.match_offset, got.buffer_done, got.match_total);
      end
      return;
    end
    want = awaited_reports.pop_front();
    if (got.match_found !== want.match_found || got.match_offset !== want.match_offset ||
        got.buffer_done !== want.buffer_done || got.match_total !== want.match_total) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("%0t: expected found=%0b offset=%0d done=%0b total=%0d", $realtime,
                 want.match_found, want.match_offset, want.buffer_done, want.match_total);
        $display("%0t:   actual found=%0b offset=%0d done=%0b total=%0d", $realtime,
                 got.match_found, got.match_offset, got.buffer_done, got.match_total);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sig_bytes = '0;
      sig_care = 8'hFF;
      sig_len = '0;
      fold_on = 1'b0;
      clear_scan();
      awaited_reports.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_PATTERN_BYTES: sig_bytes = cfg_data;
          REG_CARE_MASK: sig_care = cfg_data[CARE_BITS-1:0];
          REG_PATTERN_LENGTH: sig_len = cfg_data[LEN_W-1:0];
          REG_IGNORE_CASE: fold_on = cfg_data[0];
          default: ;
        endcase
      end
      // a word leaving now belongs to an earlier byte, so check before predicting
      if (dst_valid && !dst_stall) begin
        compare_word(dst_word);
      end
      if (src_valid && !src_stall) begin
        scan_byte(src_word);
      end
    end
    outstanding <= awaited_reports.size();
  end

endmodule

FILE: bench/tb_masked_byte_signature_matcher_unit.sv
module tb_masked_byte_signature_matcher_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import mbsm_pkg::*;

  localparam int STIM_BYTES = 1050;
  localparam int STEADY_FROM = 900;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam logic [7:0] EDGE_BYTES [10] = '{8'h00, 8'hFF, 8'h40, 8'h41, 8'h5A,
                                             8'h5B, 8'h60, 8'h61, 8'h7A, 8'h7B};

  logic                   clk;
  logic                   rst;
  logic                   src_valid;
  logic                   src_stall;
  in_word_t               src_word;
  logic                   dst_valid;
  logic                   dst_stall;
  out_word_t              dst_word;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int mismatches;
  int outstanding;
  int idle_cycles;
  int bytes_sent;
  bit steady;

  masked_byte_signature_matcher_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_word  (src_word),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_word  (dst_word),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  signature_match_checker match_check (
    .clk         (clk),
    .rst         (rst),
    .src_valid   (src_valid),
    .src_stall   (src_stall),
    .src_word    (src_word),
    .dst_valid   (dst_valid),
    .dst_stall   (dst_stall),
    .dst_word    (dst_word),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || cfg_write || (src_valid && !src_stall) || (dst_valid && !dst_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver stalls in short bursts until the steady tail
  initial begin
    dst_stall <= 1'b0;
    forever begin
      repeat ($urandom_range(1, 24)) @(posedge clk);
      if (!steady) begin
        dst_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        dst_stall <= 1'b0;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    if (!steady && $urandom_range(0, 4) == 0) begin
      src_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_word <= '{data_byte: b, last_byte: last};
    do @(posedge clk); while (!(src_valid && !src_stall));
    bytes_sent++;
  endtask

  task automatic push_string(input string s, input bit close);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i], close && i == s.len() - 1);
    end
  endtask

  // hold the sender until every word has come back, then let the pipe empty
  task automatic settle();
    src_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_signature(input logic [63:0] pat, input logic [7:0] care,
                                input int len, input bit icase);
    cfg_write <= 1'b1;
    cfg_index <= REG_PATTERN_BYTES;
    cfg_data <= pat;
    @(posedge clk);
    cfg_index <= REG_CARE_MASK;
    cfg_data <= CFG_DATA_W'(care);
    @(posedge clk);
    cfg_index <= REG_PATTERN_LENGTH;
    cfg_data <= CFG_DATA_W'(len);
    @(posedge clk);
    cfg_index <= REG_IGNORE_CASE;
    cfg_data <= CFG_DATA_W'(icase);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [63:0] letter_pattern();
    logic [63:0] p;
    for (int j = 0; j < 8; j++) begin
      p[8*j +: 8] = 8'($urandom_range(8'h41, 8'h5A)) | ($urandom_range(0, 1) ? 8'h20 : 8'h00);
    end
    return p;
  endfunction

  // one signature byte as it might show up in the data: wildcards random,
  // letters in either case when folding is on, now and then one bit off
  function automatic logic [7:0] disguised_byte(input logic [63:0] pat, input logic [7:0] care,
                                                input bit icase, input int j);
    logic [7:0] b;
    b = pat[8*j +: 8];
    if (!care[j]) begin
      b = 8'($urandom);
    end else if (icase && (b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7A &&
                 $urandom_range(0, 1) == 1) begin
      b = b ^ 8'h20;
    end
    if ($urandom_range(0, 15) == 0) begin
      b = b ^ (8'h01 << $urandom_range(0, 7));
    end
    return b;
  endfunction

  function automatic logic [7:0] filler_byte(input logic [63:0] pat);
    int j;
    case ($urandom_range(0, 3))
      0: begin
        j = $urandom_range(0, 7);
        return pat[8*j +: 8];
      end
      1: return EDGE_BYTES[$urandom_range(0, 9)];
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    logic [63:0] pat;
    logic [7:0] care;
    int len;
    bit icase;
    int phase_no;
    int phase_end;
    int blen;
    bit cut;
    logic [7:0] chunk [$];

    rst <= 1'b1;
    src_valid <= 1'b0;
    src_word <= '0;
    cfg_write <= 1'b0;
    cfg_index <= REG_PATTERN_BYTES;
    cfg_data <= '0;
    steady = 1'b0;
    bytes_sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: length zero, so only the closing word comes back
    push_string("Ab", 1'b1);
    settle();
    load_signature(64'h636261, 8'hFF, 3, 1'b0);
    push_string("ab", 1'b1);
    push_string("abcAbcabc", 1'b1);
    settle();
    // hits may not overlap
    load_signature(64'h6161, 8'hFF, 2, 1'b0);
    push_string("aaaaa", 1'b1);
    settle();
    // middle byte is a wildcard, letters folded on both sides
    load_signature(64'h437A41, 8'h05, 3, 1'b1);
    push_string("a[cAzC", 1'b1);
    settle();
    // length above the window disables matching
    load_signature(64'h0, 8'h00, 9, 1'b0);
    push_string("xyz", 1'b1);

    phase_no = 0;
    while (bytes_sent < STIM_BYTES) begin
      pat = {$urandom, $urandom};
      care = $urandom_range(0, 1) ? 8'hFF : 8'($urandom);
      len = $urandom_range(1, 4);
      icase = $urandom_range(0, 1);
      if ($urandom_range(0, 3) == 0) begin
        pat = letter_pattern();
      end
      case (phase_no)
        0: begin
          len = 8;
          care = 8'hFF;
          pat = letter_pattern();
          icase = 1'b1;
        end
        1: begin
          len = 8;
          care = 8'h00;
        end
        2: begin
          len = 1;
          pat = '0;
          care = 8'hFF;
        end
        3: begin
          len = 15;
          pat = '1;
        end
        4: len = 0;
        5: begin
          len = 8;
          pat = '1;
          care = 8'hFF;
          icase = 1'b0;
        end
        default: begin
          case ($urandom_range(0, 9))
            0: len = 0;
            1: len = $urandom_range(9, 15);
            2, 3: len = $urandom_range(5, 8);
            default: ;
          endcase
        end
      endcase
      settle();
      load_signature(pat, care, len, icase);
      phase_end = bytes_sent + $urandom_range(40, 110);
      while (bytes_sent < phase_end && bytes_sent < STIM_BYTES) begin
        blen = $urandom_range(1, 30);
        chunk.delete();
        while (chunk.size() < blen) begin
          if (len >= 1 && len <= MAX_PATTERN_BYTES && $urandom_range(0, 3) == 0) begin
            for (int j = 0; j < len; j++) begin
              chunk.insert(chunk.size(), disguised_byte(pat, care, icase, j));
            end
          end else begin
            chunk.insert(chunk.size(), filler_byte(pat));
          end
        end
        // sometimes leave the buffer open across the next settings change
        cut = (bytes_sent + chunk.size() >= phase_end) && $urandom_range(0, 2) == 0;
        steady = (bytes_sent >= STEADY_FROM);
        foreach (chunk[i]) begin
          push_byte(chunk[i], !cut && i == chunk.size() - 1);
        end
      end
      phase_no++;
    end
    settle();

    if (mismatches == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
